// ===== hdl/ictm_pkg.sv =====
// ----------------------------------------------------------------------------
// ictm_pkg: shared definitions for the interrupt controller with timers
// Action codes, bus addresses, timer slot codes and small helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ictm_pkg;

  // Item action codes
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_RAISE = 2'd3;

  // Controller register addresses
  localparam logic [31:0] ADDR_VECTOR = 32'hfffff100;
  localparam logic [31:0] ADDR_LAST   = 32'hfffff108;
  localparam logic [31:0] ADDR_MASK0  = 32'hfffff110;
  localparam logic [31:0] ADDR_MASK1  = 32'hfffff114;
  localparam logic [31:0] ADDR_IECR   = 32'hfffff120;
  localparam logic [31:0] ADDR_IDCR   = 32'hfffff124;
  localparam logic [31:0] ADDR_ICCR   = 32'hfffff128;
  localparam logic [31:0] ADDR_ID     = 32'hfff00000;
  localparam logic [31:0] ID_VALUE    = 32'h14000040;
  localparam logic [31:0] TOUCH_BASE  = 32'hff00b000;
  localparam logic [31:0] TIMER_BASE  = 32'hfffe0000;

  localparam logic [31:0] UNMAPPED    = 32'hffffffff;
  localparam logic [31:0] IRQ_MASK    = 32'h0003fffe;
  localparam logic [31:0] STATUS_FLAG = 32'h00000010;
  localparam logic [15:0] COUNT_FULL  = 16'hffff;
  localparam logic [15:0] COUNT_MARK  = 16'h1000;

  // Timer sources and default channel count
  localparam logic [4:0] FIRST_TIMER_SOURCE = 5'd4;
  localparam logic [4:0] OTHER_TIMER_SOURCE = 5'd5;
  localparam int         DEF_TIMER_CHANNELS = 3;
  localparam int         SLOT_COUNT         = 9;

  // Timer register slots within one channel
  typedef logic [3:0] slot_t;
  localparam slot_t SLOT_CCR  = 4'd0;
  localparam slot_t SLOT_CMR  = 4'd1;
  localparam slot_t SLOT_CV   = 4'd2;
  localparam slot_t SLOT_RA   = 4'd3;
  localparam slot_t SLOT_RB   = 4'd4;
  localparam slot_t SLOT_RC   = 4'd5;
  localparam slot_t SLOT_IER  = 4'd6;
  localparam slot_t SLOT_IDR  = 4'd7;
  localparam slot_t SLOT_IMR  = 4'd8;
  localparam slot_t SLOT_SR   = 4'd9;
  localparam slot_t SLOT_NONE = 4'd15;

  // Request from the controller core to the timer block
  typedef struct packed {
    logic        rd;
    logic        wr;
    logic        tick;
    logic [31:0] address;
    logic [31:0] write_data;
  } timer_req_t;

  function automatic slot_t slot_of(input logic [5:0] offset);
    slot_t s;
    unique case (offset)
      6'h00:   s = SLOT_CCR;
      6'h04:   s = SLOT_CMR;
      6'h10:   s = SLOT_CV;
      6'h14:   s = SLOT_RA;
      6'h18:   s = SLOT_RB;
      6'h1c:   s = SLOT_RC;
      6'h20:   s = SLOT_SR;
      6'h24:   s = SLOT_IER;
      6'h28:   s = SLOT_IDR;
      6'h2c:   s = SLOT_IMR;
      default: s = SLOT_NONE;
    endcase
    return s;
  endfunction

  // Lowest set bit; 0 when none is set
  function automatic logic [4:0] lowest_set(input logic [31:0] bits);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (bits[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ictm_in_if.sv =====
// ----------------------------------------------------------------------------
// ictm_in_if: input item channel
// Valid/ready channel carrying one bus access, tick or source raise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ictm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] address;
  logic [31:0] write_data;
  logic [4:0]  src_num;

  modport source (output valid, action, address, write_data, src_num, input ready);
  modport sink   (input valid, action, address, write_data, src_num, output ready);
endinterface

`default_nettype wire

// ===== hdl/ictm_out_if.sv =====
// ----------------------------------------------------------------------------
// ictm_out_if: result item channel
// Valid/ready channel carrying read data and the two interrupt lines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ictm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        fiq_n;
  logic        irq_n;

  modport source (output valid, read_data, fiq_n, irq_n, input ready);
  modport sink   (input valid, read_data, fiq_n, irq_n, output ready);
endinterface

`default_nettype wire

// ===== hdl/interrupt_controller_with_timers.sv =====
// ----------------------------------------------------------------------------
// interrupt_controller_with_timers: interrupt controller with timer counters
// Pending and mask words, vector latch, bus register map and timer channels.
// ----------------------------------------------------------------------------
// Path: an item is taken into the input register and moves on into the result
//   register (rsp.valid) once that register is free or being emptied.
// Throughput: one item per cycle while rsp.ready holds; the input register and
//   result register let a new item enter while a finished result waits.
// Reset: synchronous; pending, mask and vector cleared, counters at 0xffff.
`timescale 1ns / 1ps
`default_nettype none

module interrupt_controller_with_timers #(
  parameter int TIMER_CHANNELS = ictm_pkg::DEF_TIMER_CHANNELS
) (
  input wire         clk,
  input wire         rst,
  ictm_in_if.sink    cmd,
  ictm_out_if.source rsp
);
  import ictm_pkg::*;

  // Input register
  logic        in_valid;
  logic [1:0]  action;
  logic [31:0] address;
  logic [31:0] write_data;
  logic [4:0]  source;

  // Controller state
  logic [31:0] pending;
  logic [31:0] pending_next;
  logic [31:0] mask;
  logic [31:0] mask_next;
  logic [4:0]  last_vector;
  logic [4:0]  last_vector_next;

  // Result register
  logic        out_valid;
  logic [31:0] read_data;
  logic [31:0] read_data_next;
  logic        fiq_n;
  logic        irq_n;

  logic        advance;
  logic [4:0]  vector;
  logic [31:0] requests;
  timer_req_t  treq;
  logic [31:0] timer_rd;
  logic [31:0] timer_raise;

  // Move the held item to the result register whenever that register is free
  // or being emptied this cycle; state commits at the same edge.
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      action     <= cmd.action;
      address    <= cmd.address;
      write_data <= cmd.write_data;
      source     <= cmd.src_num;
    end
  end

  // Timer requests are only issued for the item that commits this cycle
  assign treq.rd         = advance && (action == ACT_READ);
  assign treq.wr         = advance && (action == ACT_WRITE);
  assign treq.tick       = advance && (action == ACT_TICK);
  assign treq.address    = address;
  assign treq.write_data = write_data;

  ictm_timers #(
    .TIMER_CHANNELS (TIMER_CHANNELS)
  ) u_timers (
    .clk     (clk),
    .rst     (rst),
    .req     (treq),
    .rd_data (timer_rd),
    .raise   (timer_raise)
  );

  assign vector = lowest_set(pending);

  always_comb begin
    pending_next     = pending;
    mask_next        = mask;
    last_vector_next = last_vector;
    read_data_next   = '0;
    unique case (action)
      ACT_READ: begin
        priority if (address[31:5] == TOUCH_BASE[31:5]) begin
          read_data_next = '0;
        end else if (address == ADDR_VECTOR) begin
          // hand out the lowest pending source and acknowledge it
          read_data_next   = {27'd0, vector};
          pending_next     = pending & ~(32'd1 << vector);
          last_vector_next = vector;
        end else if (address == ADDR_LAST) begin
          read_data_next = {27'd0, last_vector};
        end else if (address == ADDR_MASK0 || address == ADDR_MASK1 ||
                     address == ADDR_IECR) begin
          read_data_next = mask;
        end else if (address == ADDR_ID) begin
          read_data_next = ID_VALUE;
        end else begin
          // the timer block answers unmapped outside its own window
          read_data_next = timer_rd;
        end
      end
      ACT_WRITE: begin
        if (address == ADDR_IECR) begin
          mask_next = mask | write_data;
        end else if (address == ADDR_IDCR) begin
          mask_next = mask & ~write_data;
        end else if (address == ADDR_ICCR) begin
          pending_next = pending & ~write_data;
        end
      end
      ACT_TICK: begin
        pending_next = pending | timer_raise;
      end
      ACT_RAISE: begin
        pending_next = pending | (32'd1 << source);
      end
    endcase
  end

  assign requests = pending_next & mask_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= '0;
      mask        <= '0;
      last_vector <= '0;
    end else if (advance) begin
      pending     <= pending_next;
      mask        <= mask_next;
      last_vector <= last_vector_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Interrupt lines are taken after the item's update, active low
  always_ff @(posedge clk) begin
    if (advance) begin
      read_data <= read_data_next;
      fiq_n     <= ~requests[0];
      irq_n     <= ~|(requests & IRQ_MASK);
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = read_data;
  assign rsp.fiq_n     = fiq_n;
  assign rsp.irq_n     = irq_n;

`ifndef NO_ASSERTIONS
  // A waiting result always reflects the current pending and mask state
  a_fiq_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fiq_n == ~(pending[0] & mask[0])))
    else $error("fiq_n out of step with pending and mask");

  a_irq_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (irq_n == ~|(pending & mask & IRQ_MASK)))
    else $error("irq_n out of step with pending and mask");

  // A vector read with something pending acknowledges exactly one source
  a_vector_ack: assert property (@(posedge clk) disable iff (rst)
    (advance && action == ACT_READ && address == ADDR_VECTOR && pending != '0)
      |=> ($countones(pending) == $past($countones(pending)) - 1))
    else $error("vector read did not clear exactly one pending bit");

  // A committed item always leaves a result behind
  a_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("committed item produced no result");
`endif

endmodule

`default_nettype wire

// ===== hdl/ictm_timers.sv =====
// ----------------------------------------------------------------------------
// ictm_timers: timer counter channels
// Down counters with reload, status and channel registers, bus decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ictm_timers #(
  parameter int TIMER_CHANNELS = ictm_pkg::DEF_TIMER_CHANNELS
) (
  input  wire                 clk,
  input  wire                 rst,
  input  ictm_pkg::timer_req_t req,
  output logic [31:0]         rd_data,
  output logic [31:0]         raise
);
  import ictm_pkg::*;

  logic        in_window;
  slot_t       slot;
  logic [15:0] reload0;
  logic        reload_first;

  logic [TIMER_CHANNELS-1:0] chan_sel;
  logic [TIMER_CHANNELS-1:0] chan_fire;
  logic [31:0]               chan_rd [TIMER_CHANNELS];

  assign in_window = (req.address[31:8] == TIMER_BASE[31:8]) && (req.address[7:6] != 2'b11);
  assign slot      = slot_of(req.address[5:0]);

  for (genvar t = 0; t < TIMER_CHANNELS; t++) begin : g_chan
    localparam logic [1:0] CH_CODE = 2'(t);
    localparam bit         IS_FIRST = (t == 0);

    logic [15:0] count;
    logic [15:0] count_dec;
    logic [31:0] status;
    logic [31:0] regs [SLOT_COUNT];

    assign chan_sel[t]  = in_window && (req.address[7:6] == CH_CODE);
    assign chan_fire[t] = req.tick && (count == 16'd0);
    assign count_dec    = count - 16'd1;

    always_ff @(posedge clk) begin
      if (rst) begin
        count  <= COUNT_FULL;
        status <= '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          regs[i] <= '0;
        end
      end else begin
        if (req.tick) begin
          if (count == 16'd0) begin
            count  <= (IS_FIRST && reload_first) ? reload0 : COUNT_FULL;
            status <= status | STATUS_FLAG;
          end else begin
            count <= count_dec;
            if (count_dec == COUNT_MARK) begin
              status <= status | STATUS_FLAG;
            end
          end
        end
        if (req.wr && chan_sel[t]) begin
          if (slot == SLOT_SR) begin
            status <= req.write_data;
          end else if (slot <= SLOT_IMR) begin
            regs[slot] <= req.write_data;
            if (slot == SLOT_CV || slot == SLOT_RC) begin
              count <= req.write_data[15:0];
            end
          end
        end
        // reading the status register drops its event flag
        if (req.rd && chan_sel[t] && slot == SLOT_SR) begin
          status <= status & ~STATUS_FLAG;
        end
      end
    end

    always_comb begin
      if (slot == SLOT_SR) begin
        chan_rd[t] = status;
      end else if (slot == SLOT_CV) begin
        chan_rd[t] = {16'd0, count};
      end else if (slot <= SLOT_IMR) begin
        chan_rd[t] = regs[slot];
      end else begin
        chan_rd[t] = UNMAPPED;
      end
    end
  end

  // Reload control is shared: any channel's CCR sets it, only channel 0 uses it
  always_ff @(posedge clk) begin
    if (rst) begin
      reload0      <= COUNT_FULL;
      reload_first <= 1'b0;
    end else if (req.wr) begin
      if (|chan_sel && slot == SLOT_CCR) begin
        reload_first <= ~req.write_data[1];
      end
      if (chan_sel[0] && (slot == SLOT_CV || slot == SLOT_RC)) begin
        reload0 <= req.write_data[15:0];
      end
    end
  end

  always_comb begin
    rd_data = UNMAPPED;
    raise   = '0;
    for (int t = 0; t < TIMER_CHANNELS; t++) begin
      if (chan_sel[t]) begin
        rd_data = chan_rd[t];
      end
      if (chan_fire[t]) begin
        raise[(t == 0) ? FIRST_TIMER_SOURCE : OTHER_TIMER_SOURCE] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/interrupt_controller_with_timers_tb.sv =====
// ----------------------------------------------------------------------------
// interrupt_controller_with_timers_tb: self-checking bench for the controller
// Drives bus reads, writes, ticks and source raises through the command
// channel, predicts every response item with a cycle-free model of the
// pending, mask, vector and timer state, and checks the response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interrupt_controller_with_timers_tb;
  import ictm_pkg::*;

  localparam int NUM_CHANNELS   = DEF_TIMER_CHANNELS;
  localparam int RANDOM_ITEMS   = 400;
  localparam int IDLE_LIMIT     = 2000;  // cycles with no accepted item on either side
  localparam int SETTLE_CYCLES  = 10;    // extra wait once no response is outstanding
  localparam int REPORT_LIMIT   = 10;

  localparam logic [31:0] TIMER_END  = 32'hfffe00c0;
  localparam logic [31:0] SYS_WINDOW = 32'hfffff000;

  // Offsets of the registers inside one timer channel
  localparam logic [5:0] OFF_CCR = 6'h00;
  localparam logic [5:0] OFF_CMR = 6'h04;
  localparam logic [5:0] OFF_CV  = 6'h10;
  localparam logic [5:0] OFF_RA  = 6'h14;
  localparam logic [5:0] OFF_RB  = 6'h18;
  localparam logic [5:0] OFF_RC  = 6'h1c;
  localparam logic [5:0] OFF_SR  = 6'h20;
  localparam logic [5:0] OFF_IER = 6'h24;
  localparam logic [5:0] OFF_IDR = 6'h28;
  localparam logic [5:0] OFF_IMR = 6'h2c;
  localparam logic [5:0] OFF_BAD = 6'h30;

  typedef struct packed {
    logic [31:0] read_data;
    logic        fiq_n;
    logic        irq_n;
  } response_t;

  logic clk;
  logic rst;

  ictm_in_if  cmd_if ();
  ictm_out_if rsp_if ();

  interrupt_controller_with_timers #(
    .TIMER_CHANNELS(NUM_CHANNELS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rsp(rsp_if)
  );

  // --------------------------------------------------------------------------
  // Predicted controller state
  // --------------------------------------------------------------------------
  logic [31:0] pend_word;
  logic [31:0] mask_word;
  logic [4:0]  vector_latch;
  logic [15:0] counter_val [NUM_CHANNELS];
  logic [15:0] reload_val  [NUM_CHANNELS];
  logic        first_reload_on;
  logic [31:0] timer_status [NUM_CHANNELS];
  logic [31:0] timer_regs [NUM_CHANNELS][SLOT_COUNT];

  response_t expected_responses[$];

  int  error_count;
  int  mismatch_count;
  bit  no_idle;        // hold both sides free of gaps while set

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles in which no item moves on either channel; a hang ends the run.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  task automatic clear_model();
    pend_word       = '0;
    mask_word       = '0;
    vector_latch    = '0;
    first_reload_on = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      counter_val[c]  = COUNT_FULL;
      reload_val[c]   = COUNT_FULL;
      timer_status[c] = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        timer_regs[c][s] = '0;
      end
    end
  endtask

  // Map a channel offset to its register slot; SLOT_NONE when unknown.
  function automatic slot_t timer_slot_of(input logic [5:0] off);
    case (off)
      OFF_CCR: return SLOT_CCR;
      OFF_CMR: return SLOT_CMR;
      OFF_CV:  return SLOT_CV;
      OFF_RA:  return SLOT_RA;
      OFF_RB:  return SLOT_RB;
      OFF_RC:  return SLOT_RC;
      OFF_SR:  return SLOT_SR;
      OFF_IER: return SLOT_IER;
      OFF_IDR: return SLOT_IDR;
      OFF_IMR: return SLOT_IMR;
      default: return SLOT_NONE;
    endcase
  endfunction

  function automatic bit in_timer_window(input logic [31:0] addr);
    return (addr >= TIMER_BASE) && (addr < TIMER_END);
  endfunction

  function automatic logic [31:0] read_register(input logic [31:0] addr);
    logic [31:0] word_addr;
    logic [31:0] rd;
    int          vec;
    int          ch;
    slot_t       slot;
    word_addr = addr & ~32'h3;
    rd        = UNMAPPED;
    if ((word_addr >= TOUCH_BASE) && (word_addr <= TOUCH_BASE + 32'h1f)) begin
      rd = '0;
    end else begin
      case (addr)
        ADDR_VECTOR: begin
          // Take the lowest pending source and drop it from the pending word
          vec = 0;
          for (int i = 31; i >= 0; i--) begin
            if (pend_word[i]) begin
              vec = i;
            end
          end
          if (pend_word != '0) begin
            pend_word[vec] = 1'b0;
          end
          vector_latch = 5'(vec);
          rd = 32'(vec);
        end
        ADDR_LAST:                      rd = 32'(vector_latch);
        ADDR_MASK0, ADDR_MASK1, ADDR_IECR: rd = mask_word;
        ADDR_ID:                        rd = ID_VALUE;
        default: begin
          if (in_timer_window(addr)) begin
            ch   = int'(addr[7:6]);
            slot = timer_slot_of(addr[5:0]);
            if (ch < NUM_CHANNELS && slot != SLOT_NONE) begin
              if (slot == SLOT_SR) begin
                rd = timer_status[ch];
                timer_status[ch] = timer_status[ch] & ~STATUS_FLAG;
              end else if (slot == SLOT_CV) begin
                rd = 32'(counter_val[ch]);
              end else begin
                rd = timer_regs[ch][slot];
              end
            end
          end
        end
      endcase
    end
    return rd;
  endfunction

  function automatic void write_register(input logic [31:0] addr, input logic [31:0] data);
    int    ch;
    slot_t slot;
    if (in_timer_window(addr)) begin
      ch   = int'(addr[7:6]);
      slot = timer_slot_of(addr[5:0]);
      if (ch < NUM_CHANNELS && slot != SLOT_NONE) begin
        if (slot == SLOT_SR) begin
          timer_status[ch] = data;
        end else begin
          timer_regs[ch][slot] = data;
          if (slot == SLOT_CCR) begin
            first_reload_on = ~data[1];
          end
          if (slot == SLOT_CV || slot == SLOT_RC) begin
            counter_val[ch] = data[15:0];
            reload_val[ch]  = data[15:0];
          end
        end
      end
    end else begin
      case (addr)
        ADDR_IECR: mask_word = mask_word | data;
        ADDR_IDCR: mask_word = mask_word & ~data;
        ADDR_ICCR: pend_word = pend_word & ~data;
        default: ;
      endcase
    end
  endfunction

  function automatic void advance_timers();
    logic [4:0] src;
    for (int t = 0; t < NUM_CHANNELS; t++) begin
      if (counter_val[t] == '0) begin
        // Only the first channel may reload from its stored value
        if (t == 0 && first_reload_on) begin
          counter_val[t] = reload_val[t];
        end else begin
          counter_val[t] = COUNT_FULL;
        end
        src = (t == 0) ? FIRST_TIMER_SOURCE : OTHER_TIMER_SOURCE;
        pend_word[src] = 1'b1;
        timer_status[t] = timer_status[t] | STATUS_FLAG;
      end else begin
        counter_val[t] = counter_val[t] - 16'd1;
        if (counter_val[t] == COUNT_MARK) begin
          timer_status[t] = timer_status[t] | STATUS_FLAG;
        end
      end
    end
  endfunction

  // Apply one item to the predicted state and return the response it causes.
  function automatic response_t compute_response(input logic [1:0] action,
                                                 input logic [31:0] addr,
                                                 input logic [31:0] data,
                                                 input logic [4:0] src);
    response_t   r;
    logic [31:0] req;
    r.read_data = '0;
    case (action)
      ACT_READ:  r.read_data = read_register(addr);
      ACT_WRITE: write_register(addr, data);
      ACT_TICK:  advance_timers();
      default:   pend_word[src] = 1'b1;
    endcase
    req     = pend_word & mask_word;
    r.fiq_n = ~req[0];
    r.irq_n = ((req & IRQ_MASK) == '0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Gaps: most short, a few long
  // --------------------------------------------------------------------------
  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return 0;
    if (pick < 19) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Command side: one item per call, fields change at the falling edge
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] action, input logic [31:0] addr,
                           input logic [31:0] data, input logic [4:0] src);
    int gap;
    gap = no_idle ? 0 : gap_cycles();
    if (gap > 0) begin
      @(negedge clk);
      cmd_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_if.valid      = 1'b1;
    cmd_if.action     = action;
    cmd_if.address    = addr;
    cmd_if.write_data = data;
    cmd_if.src_num    = src;
    // Hold the item until the block takes it
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    expected_responses.push_back(compute_response(action, addr, data, src));
  endtask

  task automatic reg_read(input logic [31:0] addr);
    send_item(ACT_READ, addr, $urandom, 5'($urandom));
  endtask

  task automatic reg_write(input logic [31:0] addr, input logic [31:0] data);
    send_item(ACT_WRITE, addr, data, 5'($urandom));
  endtask

  // Drop valid and hold off until every predicted response has arrived.
  task automatic wait_for_drain();
    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Response side: random back-pressure, changed at the falling edge
  // --------------------------------------------------------------------------
  initial begin : response_sink
    int stall;
    stall = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0 && !no_idle) begin
        rsp_if.ready = 1'b0;
        stall--;
      end else begin
        rsp_if.ready = 1'b1;
        stall = 0;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
          stall = gap_cycles();
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input response_t want,
                                 input response_t got);
    error_count++;
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected read_data=%h fiq_n=%b irq_n=%b,",
               $realtime, what, want.read_data, want.fiq_n, want.irq_n);
      $display("  got read_data=%h fiq_n=%b irq_n=%b",
               got.read_data, got.fiq_n, got.irq_n);
    end
  endtask

  // Compare each accepted response with the oldest prediction.
  always @(posedge clk) begin : check_responses
    response_t want;
    response_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got.read_data = rsp_if.read_data;
      got.fiq_n     = rsp_if.fiq_n;
      got.irq_n     = rsp_if.irq_n;
      if (expected_responses.size() == 0) begin
        report_mismatch("response with no prediction", '0, got);
      end else begin
        want = expected_responses.pop_front();
        if (got.read_data !== want.read_data || got.fiq_n !== want.fiq_n ||
            got.irq_n !== want.irq_n) begin
          report_mismatch("response mismatch", want, got);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------
  // Reset values, identity word, touch window and unmapped corners.
  task automatic test_reset_values();
    reg_read(ADDR_VECTOR);                      // empty vector read
    reg_read(ADDR_LAST);
    reg_read(ADDR_ID);
    reg_read(TOUCH_BASE + 32'h1f);              // touch window, top byte
    reg_read(ADDR_IDCR);                        // write-only, reads unmapped
    reg_read(TIMER_END + 32'h4);                // past the timer channels, unmapped
    reg_read(TIMER_BASE | 32'(OFF_CV));         // counter at full scale
    reg_read(32'h0);
    reg_read(32'hffffffff);
  endtask

  // Mask set and clear, pending clear, vector order and both interrupt lines.
  task automatic test_vector_and_lines();
    reg_write(ADDR_IECR, 32'hffffffff);
    send_item(ACT_RAISE, '0, '0, 5'd0);         // fast line
    send_item(ACT_RAISE, '0, '1, 5'd17);        // top of the normal range
    send_item(ACT_RAISE, '1, '0, 5'd31);        // outside both line ranges
    reg_read(ADDR_VECTOR);
    reg_read(ADDR_VECTOR);
    reg_write(ADDR_ICCR, 32'hffffffff);
    reg_write(ADDR_IDCR, 32'hffffffff);
  endtask

  // Reload at zero, the status mark, status clear on read, unknown offset.
  task automatic test_timer_counters();
    reg_write(TIMER_BASE | 32'(OFF_CCR), 32'h0);          // reload enabled
    reg_write(TIMER_BASE | 32'(OFF_RC), 32'hffff0001);
    send_item(ACT_TICK, '0, '0, '0);
    send_item(ACT_TICK, '0, '0, '0);                     // wraps, raises source
    reg_write(TIMER_BASE | 32'h40 | 32'(OFF_CV), 32'h00001001);
    send_item(ACT_TICK, '0, '0, '0);                     // reaches the mark
    reg_read(TIMER_BASE | 32'h40 | 32'(OFF_SR));
    reg_read(TIMER_BASE | 32'h40 | 32'(OFF_SR));
    reg_write(TIMER_BASE | 32'h80 | 32'(OFF_BAD), 32'hffffffff);
    reg_read(TIMER_BASE | 32'(OFF_CV));
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------
  function automatic logic [5:0] known_offset(input int idx);
    case (idx)
      0:       return OFF_CCR;
      1:       return OFF_CMR;
      2:       return OFF_CV;
      3:       return OFF_RA;
      4:       return OFF_RB;
      5:       return OFF_RC;
      6:       return OFF_SR;
      7:       return OFF_IER;
      8:       return OFF_IDR;
      default: return OFF_IMR;
    endcase
  endfunction

  function automatic logic [31:0] timer_address();
    logic [5:0] off;
    if ($urandom_range(0, 7) == 0) begin
      off = 6'($urandom);
    end else begin
      off = known_offset($urandom_range(0, 9));
    end
    return TIMER_BASE | 32'($urandom_range(0, 2) << 6) | 32'(off);
  endfunction

  function automatic logic [31:0] read_address();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1, 2: return ADDR_VECTOR;
      3: begin
        case ($urandom_range(0, 6))
          0:       return ADDR_LAST;
          1:       return ADDR_MASK0;
          2:       return ADDR_MASK1;
          3:       return ADDR_IECR;
          4:       return ADDR_IDCR;
          5:       return ADDR_ICCR;
          default: return ADDR_ID;
        endcase
      end
      4, 5, 6: return timer_address();
      7: return TOUCH_BASE + 32'($urandom_range(0, 35));
      8: return TIMER_END + 32'($urandom_range(0, 15));
      default: return SYS_WINDOW + 32'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [31:0] write_address();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1, 2: return ADDR_IECR;
      3: return ADDR_IDCR;
      4: return ADDR_ICCR;
      5, 6, 7, 8: return timer_address();
      default: return read_address();
    endcase
  endfunction

  task automatic random_item();
    logic [31:0] addr;
    logic [31:0] data;
    int          pick;
    pick = $urandom_range(0, 19);
    data = $urandom;
    if (pick < 7) begin
      reg_read(read_address());
    end else if (pick < 13) begin
      addr = write_address();
      // Keep most counter loads small or near the mark so that both come round
      if (in_timer_window(addr) && (addr[5:0] == OFF_CV || addr[5:0] == OFF_RC) &&
          $urandom_range(0, 3) != 0) begin
        data[15:0] = $urandom_range(0, 1) ? 16'($urandom_range(0, 30))
                                          : COUNT_MARK + 16'($urandom_range(0, 6));
      end else if (addr == ADDR_IDCR || addr == ADDR_ICCR) begin
        data = $urandom & $urandom;
      end
      reg_write(addr, data);
    end else if (pick < 17) begin
      send_item(ACT_TICK, $urandom, data, 5'($urandom));
    end else begin
      send_item(ACT_RAISE, $urandom, data, 5'($urandom));
    end
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      // One stretch with no idling on either side
      no_idle = (i >= count / 4) && (i < count / 4 + 60);
      if (i == count / 2) begin
        wait_for_drain();
      end
      random_item();
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    error_count       = 0;
    mismatch_count    = 0;
    no_idle           = 1'b0;
    rst               = 1'b1;
    cmd_if.valid      = 1'b0;
    cmd_if.action     = ACT_READ;
    cmd_if.address    = '0;
    cmd_if.write_data = '0;
    cmd_if.src_num    = '0;
    clear_model();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_vector_and_lines();
    test_timer_counters();
    test_random_traffic(RANDOM_ITEMS);

    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_responses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ictm_pkg.sv
hdl/ictm_in_if.sv
hdl/ictm_out_if.sv
hdl/ictm_timers.sv
hdl/interrupt_controller_with_timers.sv
sim/interrupt_controller_with_timers_tb.sv
